### sv/flac_metadata_stream_parser_assert.svh
// Assertion macros shared by the checker of the FLAC metadata parser.
`ifndef FLAC_METADATA_STREAM_PARSER_ASSERT_SVH
`define FLAC_METADATA_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FMP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fmp assertion failed");

// Next-cycle implication, checked outside reset.
`define FMP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fmp assertion failed");

`endif

### sv/fmp_pkg.sv
// Types and constants of the FLAC metadata parser.
package fmp_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC  = 4'd0,
    PH_HEADER = 4'd1,
    PH_SKIP   = 4'd2,
    PH_INFO   = 4'd3,
    PH_VLEN   = 4'd4,
    PH_VSKIP  = 4'd5,
    PH_COUNT  = 4'd6,
    PH_FLEN   = 4'd7,
    PH_NAME   = 4'd8,
    PH_VALUE  = 4'd9,
    PH_DONE   = 4'd10
  } phase_e;

  localparam logic [31:0] MAGIC_WORD = 32'h664C6143;
  localparam logic [23:0] SIZE_CAP   = 24'h100000;
  localparam int          NUM_TAGS   = 10;
  localparam int          DATE_TAG   = 5;
  localparam int          DATE_LIMIT = 31;

  localparam logic [3:0] KIND_RATE     = 4'd0;
  localparam logic [3:0] KIND_CHANNELS = 4'd1;
  localparam logic [3:0] KIND_BITS     = 4'd2;
  localparam logic [3:0] KIND_SAMPLES  = 4'd3;
  localparam logic [3:0] KIND_DURATION = 4'd4;
  localparam logic [3:0] KIND_TAG_BASE = 4'd5;
  localparam logic [3:0] KIND_STATUS   = 4'd15;

  localparam logic [7:0] CHAR_EQ   = 8'h3D;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_LA   = 8'h61;
  localparam logic [7:0] CHAR_LZ   = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // Tag names, right-justified in 11 characters.
  localparam logic [87:0] TAG_TEXT [NUM_TAGS] = '{
    88'("TITLE"), 88'("ARTIST"), 88'("ALBUM"), 88'("ALBUMARTIST"), 88'("GENRE"),
    88'("DATE"), 88'("TRACKNUMBER"), 88'("TRACKTOTAL"), 88'("DISCNUMBER"),
    88'("DISCTOTAL")
  };
  localparam logic [4:0] TAG_LEN [NUM_TAGS] = '{
    5'd5, 5'd6, 5'd5, 5'd11, 5'd5, 5'd4, 5'd11, 5'd10, 5'd10, 5'd9
  };

  // Character at position pos of tag t; valid only when pos < TAG_LEN[t].
  function automatic logic [7:0] tag_char(input int t, input logic [4:0] pos);
    int k;
    k = int'(TAG_LEN[t]) - 1 - int'(pos);
    if (k < 0) begin
      k = 0;
    end
    return TAG_TEXT[t][8*k +: 8];
  endfunction

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       pop;
    logic [2:0] idx;
  } fmp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0] step_nres;
    logic       step_info;
    logic       div_done;
    logic       out_free;
    logic [2:0] nres;
  } fmp_sts_t;

endpackage

### sv/fmp_if.sv
// Stream interfaces for bytes in and results out.
interface fmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_marker;
  modport source (output valid, output data_byte, output end_marker, input ready);
  modport sink (input valid, input data_byte, input end_marker, output ready);
endinterface

interface fmp_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  item_kind;
  logic [31:0] item_value;
  logic        string_clear;
  logic        run_last;
  modport source (output valid, output item_kind, output item_value, output string_clear,
                  output run_last, input ready);
  modport sink (input valid, input item_kind, input item_value, input string_clear,
                input run_last, output ready);
endinterface

### sv/fmp_div.sv
// Restoring divider for the duration: one quotient bit per cycle.
module fmp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [45:0] dividend_i,
  input  logic [19:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [45:0] num_q;
  logic [19:0] rem_q;
  logic [19:0] den_q;
  logic [31:0] quot_q;
  logic        done_q;
  logic [20:0] trial;
  logic        fits;

  // Shift one dividend bit into the partial remainder
  assign trial = {rem_q, num_q[45]};
  assign fits  = trial >= {1'b0, den_q};

  // Control: count through all dividend bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd45;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  // Data: subtract when the divisor fits, keep low quotient bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[44:0], 1'b0};
      rem_q  <= fits ? 20'(trial - {1'b0, den_q}) : trial[19:0];
      quot_q <= {quot_q[30:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### sv/fmp_dp.sv
// Datapath: parse state, per-byte update, result slots, divider and output register.
module fmp_dp #(
  parameter int STRING_LIMIT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fmp_pkg::fmp_cmd_t cmd_i,
  output fmp_pkg::fmp_sts_t sts_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_marker_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [3:0]        item_kind_o,
  output logic [31:0]       item_value_o,
  output logic              string_clear_o,
  output logic              run_last_o
);

  localparam int VLW = (STRING_LIMIT > 2) ? $clog2(STRING_LIMIT) : 1;
  localparam logic [VLW-1:0] STR_LIM  = VLW'(STRING_LIMIT - 1);
  localparam logic [VLW-1:0] DATE_LIM =
      VLW'((STRING_LIMIT - 1 > fmp_pkg::DATE_LIMIT) ? fmp_pkg::DATE_LIMIT : STRING_LIMIT - 1);

  fmp_pkg::phase_e ph_q, ph_d;
  logic [23:0]    off_q, off_d;
  logic [23:0]    bl_q, bl_d;
  logic [6:0]     bk_q, bk_d;
  logic           fb_q, fb_d;
  logic [63:0]    wg_q, wg_d;
  logic [31:0]    cl_q, cl_d;
  logic [31:0]    fl_q, fl_d;
  logic [9:0]     flg_q, flg_d;
  logic [4:0]     nl_q, nl_d;
  logic [VLW-1:0] vl_q, vl_d;
  logic [31:0]    na_q, na_d;
  logic           ds_q, ds_d;
  logic           mf_q, mf_d;

  logic [3:0]  rk_q [2];
  logic [31:0] rv_q [2];
  logic        rc_q [2];
  logic [3:0]  rk_d [2];
  logic [31:0] rv_d [2];
  logic        rc_d [2];
  logic [1:0]  nres_d;
  logic        info_d;
  logic [2:0]  nres_q;
  logic        info_q;

  logic        ov_q;
  logic [3:0]  ok_q;
  logic [31:0] oval_q;
  logic        oc_q;
  logic        ol_q;

  logic        div_done;
  logic [31:0] div_quot;
  logic [35:0] total;
  logic [45:0] prod;

  // Lowest set flag selects the tag
  function automatic logic [4:0] find_tag(input logic [9:0] f);
    logic [4:0] r;
    r = 5'h1F;
    for (int t = fmp_pkg::NUM_TAGS - 1; t >= 0; t--) begin
      if (f[t]) begin
        r = 5'(t);
      end
    end
    return r;
  endfunction

  // Per-byte update of the parse state and its results
  always_comb begin
    logic [7:0]  b;
    logic [23:0] idx;
    logic [23:0] rem;
    logic        got;
    logic [4:0]  tg;
    logic        tv;
    logic [9:0]  sel;
    logic [7:0]  c;
    logic        dig;
    ph_d = ph_q; off_d = off_q; bl_d = bl_q; bk_d = bk_q; fb_d = fb_q; wg_d = wg_q;
    cl_d = cl_q; fl_d = fl_q; flg_d = flg_q; nl_d = nl_q; vl_d = vl_q; na_d = na_q;
    ds_d = ds_q; mf_d = mf_q;
    rk_d = rk_q; rv_d = rv_q; rc_d = rc_q;
    nres_d = '0;
    info_d = 1'b0;
    b = data_byte_i;
    idx = '0; rem = '0; got = 1'b0; sel = '0; c = '0; dig = 1'b0;
    tg = find_tag(flg_q);
    tv = (tg != 5'h1F);
    if (end_marker_i) begin
      // Flush a pending number, then report status and restart
      if (ph_q == fmp_pkg::PH_VALUE && tv && tg > 5'(fmp_pkg::DATE_TAG) && !ds_q) begin
        rk_d[0] = fmp_pkg::KIND_TAG_BASE + tg[3:0]; rv_d[0] = na_q; rc_d[0] = 1'b0;
        nres_d = 2'd1;
      end
      rk_d[nres_d[0]] = fmp_pkg::KIND_STATUS;
      rv_d[nres_d[0]] = {31'd0, mf_q || ph_q == fmp_pkg::PH_MAGIC};
      rc_d[nres_d[0]] = 1'b0;
      nres_d = nres_d + 2'd1;
      ph_d = fmp_pkg::PH_MAGIC; off_d = '0; bl_d = '0; bk_d = '0; fb_d = 1'b0; wg_d = '0;
      cl_d = '0; fl_d = '0; flg_d = '1; nl_d = '0; vl_d = '0; na_d = '0; ds_d = 1'b0;
      mf_d = 1'b0;
    end else begin
      case (ph_q)
        fmp_pkg::PH_MAGIC, fmp_pkg::PH_HEADER: begin
          wg_d = {32'd0, wg_q[23:0], b};
          if (nl_q == 5'd3) begin
            nl_d = '0;
            got = 1'b1;
          end else begin
            nl_d = nl_q + 5'd1;
          end
          if (got && ph_q == fmp_pkg::PH_MAGIC) begin
            if (wg_d[31:0] == fmp_pkg::MAGIC_WORD) begin
              ph_d = fmp_pkg::PH_HEADER;
            end else begin
              mf_d = 1'b1;
              ph_d = fmp_pkg::PH_DONE;
            end
            wg_d = '0;
          end else if (got) begin
            fb_d = wg_d[31];
            bk_d = wg_d[30:24];
            bl_d = wg_d[23:0];
            off_d = '0;
            nl_d = '0;
            wg_d = '0;
            if (bl_d == '0) begin
              ph_d = fb_d ? fmp_pkg::PH_DONE : fmp_pkg::PH_HEADER;
            end else if (bl_d >= fmp_pkg::SIZE_CAP) begin
              ph_d = fmp_pkg::PH_SKIP;
            end else if (bk_d == 7'd0) begin
              ph_d = fmp_pkg::PH_INFO;
            end else if (bk_d == 7'd4 && bl_d >= 24'd8) begin
              ph_d = fmp_pkg::PH_VLEN;
            end else begin
              ph_d = fmp_pkg::PH_SKIP;
            end
          end
        end
        fmp_pkg::PH_SKIP, fmp_pkg::PH_INFO, fmp_pkg::PH_VLEN, fmp_pkg::PH_VSKIP,
        fmp_pkg::PH_COUNT, fmp_pkg::PH_FLEN, fmp_pkg::PH_NAME, fmp_pkg::PH_VALUE: begin
          idx = off_q;
          off_d = off_q + 24'd1;
          rem = (bl_q >= off_d) ? bl_q - off_d : '0;
          // Little-endian word gather for length and count fields
          if (ph_q == fmp_pkg::PH_VLEN || ph_q == fmp_pkg::PH_COUNT ||
              ph_q == fmp_pkg::PH_FLEN) begin
            wg_d = {32'd0, b, wg_q[31:8]};
            if (nl_q == 5'd3) begin
              nl_d = '0;
              got = 1'b1;
            end else begin
              nl_d = nl_q + 5'd1;
            end
          end
          case (ph_q)
            fmp_pkg::PH_INFO: begin
              if (idx >= 24'd10 && idx <= 24'd17) begin
                wg_d = {wg_q[55:0], b};
              end
              if (idx == 24'd17 && bl_q >= 24'd18) begin
                info_d = 1'b1;
              end
            end
            fmp_pkg::PH_VLEN: begin
              if (got) begin
                fl_d = wg_d[31:0];
                if (fl_d > {8'd0, rem}) begin
                  ph_d = fmp_pkg::PH_SKIP;
                end else if (fl_d == '0) begin
                  nl_d = '0;
                  ph_d = (rem < 24'd4) ? fmp_pkg::PH_SKIP : fmp_pkg::PH_COUNT;
                end else begin
                  ph_d = fmp_pkg::PH_VSKIP;
                end
              end
            end
            fmp_pkg::PH_VSKIP: begin
              fl_d = fl_q - 32'd1;
              if (fl_d == '0) begin
                nl_d = '0;
                ph_d = (rem < 24'd4) ? fmp_pkg::PH_SKIP : fmp_pkg::PH_COUNT;
              end
            end
            fmp_pkg::PH_COUNT: begin
              if (got) begin
                cl_d = wg_d[31:0];
                nl_d = '0;
                ph_d = (cl_d == '0 || rem < 24'd4) ? fmp_pkg::PH_SKIP : fmp_pkg::PH_FLEN;
              end
            end
            fmp_pkg::PH_FLEN: begin
              if (got) begin
                fl_d = wg_d[31:0];
                if (fl_d > {8'd0, rem}) begin
                  ph_d = fmp_pkg::PH_SKIP;
                end else if (fl_d == '0) begin
                  cl_d = cl_q - 32'd1;
                  nl_d = '0;
                  ph_d = (cl_d == '0 || rem < 24'd4) ? fmp_pkg::PH_SKIP : fmp_pkg::PH_FLEN;
                end else begin
                  ph_d = fmp_pkg::PH_NAME;
                  nl_d = '0;
                  flg_d = '1;
                end
              end
            end
            fmp_pkg::PH_NAME: begin
              fl_d = fl_q - 32'd1;
              if (b == fmp_pkg::CHAR_EQ) begin
                // Keep the tag whose length matches the name
                if (nl_q != '0) begin
                  for (int t = 0; t < fmp_pkg::NUM_TAGS; t++) begin
                    if (flg_q[t] && fmp_pkg::TAG_LEN[t] == nl_q) begin
                      sel = 10'(1) << t;
                    end
                  end
                end
                flg_d = sel;
                vl_d = '0;
                na_d = '0;
                ds_d = 1'b0;
                ph_d = fmp_pkg::PH_VALUE;
                tg = find_tag(sel);
                tv = (tg != 5'h1F);
                if (tv && tg <= 5'(fmp_pkg::DATE_TAG)) begin
                  rk_d[0] = fmp_pkg::KIND_TAG_BASE + tg[3:0]; rv_d[0] = '0; rc_d[0] = 1'b1;
                  nres_d = 2'd1;
                end
                if (fl_d == '0) begin
                  if (tv && tg > 5'(fmp_pkg::DATE_TAG)) begin
                    rk_d[0] = fmp_pkg::KIND_TAG_BASE + tg[3:0]; rv_d[0] = '0; rc_d[0] = 1'b0;
                    nres_d = 2'd1;
                    ds_d = 1'b1;
                  end
                  cl_d = cl_q - 32'd1;
                  nl_d = '0;
                  ph_d = (cl_d == '0 || rem < 24'd4) ? fmp_pkg::PH_SKIP : fmp_pkg::PH_FLEN;
                end
              end else begin
                // Drop tags that no longer match, ignoring case
                c = (b >= fmp_pkg::CHAR_LA && b <= fmp_pkg::CHAR_LZ) ? b - fmp_pkg::CASE_DIFF : b;
                for (int t = 0; t < fmp_pkg::NUM_TAGS; t++) begin
                  if (nl_q >= fmp_pkg::TAG_LEN[t] || c != fmp_pkg::tag_char(t, nl_q)) begin
                    flg_d[t] = 1'b0;
                  end
                end
                if (nl_q < 5'd31) begin
                  nl_d = nl_q + 5'd1;
                end
                if (fl_d == '0) begin
                  cl_d = cl_q - 32'd1;
                  nl_d = '0;
                  ph_d = (cl_d == '0 || rem < 24'd4) ? fmp_pkg::PH_SKIP : fmp_pkg::PH_FLEN;
                end
              end
            end
            fmp_pkg::PH_VALUE: begin
              fl_d = fl_q - 32'd1;
              dig = (b >= fmp_pkg::CHAR_0 && b <= fmp_pkg::CHAR_9);
              if (tv && tg <= 5'(fmp_pkg::DATE_TAG)) begin
                if (vl_q < ((tg == 5'(fmp_pkg::DATE_TAG)) ? DATE_LIM : STR_LIM)) begin
                  rk_d[0] = fmp_pkg::KIND_TAG_BASE + tg[3:0]; rv_d[0] = {24'd0, b};
                  rc_d[0] = 1'b0;
                  nres_d = 2'd1;
                  vl_d = vl_q + VLW'(1);
                end
              end else if (tv && !ds_q) begin
                if (vl_q < STR_LIM && dig) begin
                  na_d = (na_q << 3) + (na_q << 1) + {24'd0, b - fmp_pkg::CHAR_0};
                  vl_d = vl_q + VLW'(1);
                end
                if (!(vl_q < STR_LIM && dig) || fl_d == '0) begin
                  rk_d[0] = fmp_pkg::KIND_TAG_BASE + tg[3:0]; rv_d[0] = na_d; rc_d[0] = 1'b0;
                  nres_d = 2'd1;
                  ds_d = 1'b1;
                end
              end
              if (fl_d == '0) begin
                cl_d = cl_q - 32'd1;
                nl_d = '0;
                ph_d = (cl_d == '0 || rem < 24'd4) ? fmp_pkg::PH_SKIP : fmp_pkg::PH_FLEN;
              end
            end
            default: begin
            end
          endcase
          // End of block body
          if (rem == '0) begin
            ph_d = fb_q ? fmp_pkg::PH_DONE : fmp_pkg::PH_HEADER;
            nl_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= fmp_pkg::PH_MAGIC; off_q <= '0; bl_q <= '0; bk_q <= '0; fb_q <= 1'b0;
      wg_q <= '0; cl_q <= '0; fl_q <= '0; flg_q <= '1; nl_q <= '0; vl_q <= '0;
      na_q <= '0; ds_q <= 1'b0; mf_q <= 1'b0; nres_q <= '0; info_q <= 1'b0;
    end else if (cmd_i.load) begin
      ph_q <= ph_d; off_q <= off_d; bl_q <= bl_d; bk_q <= bk_d; fb_q <= fb_d;
      wg_q <= wg_d; cl_q <= cl_d; fl_q <= fl_d; flg_q <= flg_d; nl_q <= nl_d; vl_q <= vl_d;
      na_q <= na_d; ds_q <= ds_d; mf_q <= mf_d;
      nres_q <= info_d ? 3'd5 : {1'b0, nres_d};
      info_q <= info_d;
    end
  end

  // Result slots for the accepted byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rk_q <= rk_d;
      rv_q <= rv_d;
      rc_q <= rc_d;
    end
  end

  // Duration: total samples times 1000 over the sample rate
  assign total = {wg_q[35:32], wg_q[31:0]};
  assign prod  = ({10'd0, total} << 10) - ({10'd0, total} << 5) + ({10'd0, total} << 3);

  fmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod),
    .divisor_i  (wg_q[63:44]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Output register: load the selected result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.pop) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      ol_q <= (cmd_i.idx == nres_q - 3'd1);
      oc_q <= 1'b0;
      if (info_q) begin
        case (cmd_i.idx)
          3'd0: begin ok_q <= fmp_pkg::KIND_RATE; oval_q <= {12'd0, wg_q[63:44]}; end
          3'd1: begin
            ok_q <= fmp_pkg::KIND_CHANNELS; oval_q <= {29'd0, wg_q[43:41]} + 32'd1;
          end
          3'd2: begin
            ok_q <= fmp_pkg::KIND_BITS; oval_q <= {27'd0, wg_q[40:36]} + 32'd1;
          end
          3'd3: begin ok_q <= fmp_pkg::KIND_SAMPLES; oval_q <= wg_q[31:0]; end
          default: begin
            ok_q <= fmp_pkg::KIND_DURATION;
            oval_q <= (wg_q[63:44] == '0) ? '0 : div_quot;
          end
        endcase
      end else begin
        ok_q   <= rk_q[cmd_i.idx[0]];
        oval_q <= rv_q[cmd_i.idx[0]];
        oc_q   <= rc_q[cmd_i.idx[0]];
      end
    end
  end

  assign sts_o.step_nres = nres_d;
  assign sts_o.step_info = info_d;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !ov_q || out_ready_i;
  assign sts_o.nres      = nres_q;

  assign out_valid_o    = ov_q;
  assign item_kind_o    = ok_q;
  assign item_value_o   = oval_q;
  assign string_clear_o = oc_q;
  assign run_last_o     = ol_q;

endmodule

### sv/fmp_ctrl.sv
// Controller: accept a byte, run the divider when needed, hand out result beats.
module fmp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output fmp_pkg::fmp_cmd_t cmd_o,
  input  fmp_pkg::fmp_sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } state_e;

  state_e     state_q;
  logic [2:0] idx_q;
  logic       accept;
  logic       pop;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign pop        = (state_q == S_EMIT) && sts_i.out_free;

  assign cmd_o.load      = accept;
  assign cmd_o.div_start = (state_q == S_DIV_GO);
  assign cmd_o.pop       = pop;
  assign cmd_o.idx       = idx_q;

  // Sequence one byte through its results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (accept) begin
            if (sts_i.step_info) begin
              state_q <= S_DIV_GO;
            end else if (sts_i.step_nres != '0) begin
              state_q <= S_EMIT;
            end
          end
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (sts_i.div_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (pop) begin
            if (idx_q == sts_i.nres - 3'd1) begin
              state_q <= S_IDLE;
              idx_q   <= '0;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/flac_metadata_stream_parser.sv
// Top level of the FLAC metadata stream parser.
// Use: feed the file one byte per beat on in_ch_i (data_byte), then one beat
// with end_marker set; the parser returns to its reset state after that beat.
// Results leave on out_ch_o: item_kind, item_value, string_clear, and run_last
// on the final result caused by one input beat; a status result (kind 15) ends
// every file.
// Timing: one byte is taken at a time. A byte with n results then hands them
// out one by one while the receiver is ready, the output register holding
// each beat. The last byte of the STREAMINFO fields first runs the duration
// divider, which retires one quotient bit per cycle over the 46-bit product.
// Reset: asynchronous, active low; clears the parse state to the magic check
// and empties the output register. No clearing pass is needed.
// Stall: while the receiver holds ready low, the current beat stays on the
// port and no further input is accepted until the last result of the current
// byte has been loaded into the output register.
module flac_metadata_stream_parser #(
  parameter int STRING_LIMIT = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fmp_byte_if.sink     in_ch_i,
  fmp_result_if.source out_ch_o
);

  fmp_pkg::fmp_cmd_t cmd;
  fmp_pkg::fmp_sts_t sts;

  fmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .in_ready_o (in_ch_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  fmp_dp #(
    .STRING_LIMIT (STRING_LIMIT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .data_byte_i    (in_ch_i.data_byte),
    .end_marker_i   (in_ch_i.end_marker),
    .out_ready_i    (out_ch_o.ready),
    .out_valid_o    (out_ch_o.valid),
    .item_kind_o    (out_ch_o.item_kind),
    .item_value_o   (out_ch_o.item_value),
    .string_clear_o (out_ch_o.string_clear),
    .run_last_o     (out_ch_o.run_last)
  );

endmodule

### sv/fmp_checker.sv
// Port-level checker of the FLAC metadata parser and its bind.
`include "flac_metadata_stream_parser_assert.svh"

module fmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  item_kind_i,
  input logic [31:0] item_value_i,
  input logic        string_clear_i,
  input logic        run_last_i
);

  // No new byte while results of the current one are still pending
  `FMP_ASSERT_IMP(a_no_accept_mid_run, out_valid_i && !run_last_i, !in_ready_i)
  // Status always closes the run of its byte
  `FMP_ASSERT_IMP(a_status_last, out_valid_i && item_kind_i == fmp_pkg::KIND_STATUS, run_last_i)
  // A clear beat carries no byte and belongs to a string tag
  `FMP_ASSERT_IMP(a_clear_kind, out_valid_i && string_clear_i,
                  item_value_i == 32'd0 && item_kind_i >= fmp_pkg::KIND_TAG_BASE &&
                  item_kind_i <= fmp_pkg::KIND_TAG_BASE + 4'(fmp_pkg::DATE_TAG))
  // A stalled beat holds
  `FMP_ASSERT_NXT(a_hold, out_valid_i && !out_ready_i,
                  out_valid_i && $stable(item_kind_i) && $stable(item_value_i))

endmodule

bind flac_metadata_stream_parser fmp_checker u_fmp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_ch_i.ready),
  .out_valid_i    (out_ch_o.valid),
  .out_ready_i    (out_ch_o.ready),
  .item_kind_i    (out_ch_o.item_kind),
  .item_value_i   (out_ch_o.item_value),
  .string_clear_i (out_ch_o.string_clear),
  .run_last_i     (out_ch_o.run_last)
);
